/* rtl/wsre_pkg.sv */
// Package for the world-state rule evaluator: field widths, operation and test codes,
// and the packed item, result and control types shared by the execute logic and the top level.
// No dependencies.
package wsre_pkg;

  localparam int NUM_KEYS_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int KEY_W           = 6;
  localparam int CFG_W           = 7;
  localparam int LIT_W           = 32;

  // Operation codes.
  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_EFFECT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_WRITE  = 2'd3;

  // Condition tests.
  localparam logic [2:0] TEST_EQ       = 3'd0;
  localparam logic [2:0] TEST_NE       = 3'd1;
  localparam logic [2:0] TEST_GT       = 3'd2;
  localparam logic [2:0] TEST_GE       = 3'd3;
  localparam logic [2:0] TEST_LT       = 3'd4;
  localparam logic [2:0] TEST_LE       = 3'd5;
  localparam logic [2:0] TEST_IS_TRUE  = 3'd6;
  localparam logic [2:0] TEST_IS_FALSE = 3'd7;

  // Effect codes; the remaining codes do nothing.
  localparam logic [2:0] EFF_SET = 3'd0;
  localparam logic [2:0] EFF_INC = 3'd1;
  localparam logic [2:0] EFF_DEC = 3'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [KEY_W-1:0]        left_key;
    logic [KEY_W-1:0]        right_key;
    logic                    rhs_is_literal;
    logic signed [LIT_W-1:0] literal_value;
    logic [2:0]              test_or_effect;
    logic                    first_in_chain;
    logic                    link_to_next;
  } item_t;

  typedef struct packed {
    logic                    chain_result;
    logic signed [LIT_W-1:0] read_value;
    logic                    ok;
  } result_t;

  // State updates that the execute logic asks of the top level.
  typedef struct packed {
    logic wr_en;
    logic chain_wr;
    logic chain_val;
  } ctl_t;

endpackage

/* rtl/wsre_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/wsre_exec.sv */
// Execute logic of the world-state rule evaluator: range check, condition test, chain
// fold, effect arithmetic and result formation for one item. Depends on wsre_pkg.
module wsre_exec import wsre_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  item_t                         item,
  input  logic                          left_in_range,
  input  logic                          right_in_range,
  input  logic signed [VALUE_WIDTH-1:0] left_val,
  input  logic signed [VALUE_WIDTH-1:0] right_entry,
  input  logic                          running,
  input  logic                          prev_link,
  output ctl_t                          ctl,
  output logic signed [VALUE_WIDTH-1:0] wr_data,
  output result_t                       result
);

  logic                          ok;
  logic                          uses_right;
  logic signed [VALUE_WIDTH-1:0] lit_val;
  logic signed [VALUE_WIDTH-1:0] right_val;
  logic                          test_hit;
  logic                          chain_new;
  logic                          is_effect_code;

  assign uses_right = (item.op == OP_CHECK || item.op == OP_EFFECT) && !item.rhs_is_literal;
  assign ok         = left_in_range && !(uses_right && !right_in_range);
  assign lit_val    = VALUE_WIDTH'(item.literal_value);
  assign right_val  = item.rhs_is_literal ? lit_val : right_entry;

  always_comb begin
    case (item.test_or_effect)
      TEST_EQ:      test_hit = (left_val == right_val);
      TEST_NE:      test_hit = (left_val != right_val);
      TEST_GT:      test_hit = (left_val > right_val);
      TEST_GE:      test_hit = (left_val >= right_val);
      TEST_LT:      test_hit = (left_val < right_val);
      TEST_LE:      test_hit = (left_val <= right_val);
      TEST_IS_TRUE: test_hit = (left_val != '0);
      default:      test_hit = (left_val == '0);
    endcase
  end

  always_comb begin
    if (item.first_in_chain) begin
      chain_new = test_hit;
    end else if (prev_link) begin
      chain_new = running | test_hit;
    end else begin
      chain_new = running & test_hit;
    end
  end

  always_comb begin
    case (item.test_or_effect)
      EFF_SET: wr_data = right_val;
      EFF_INC: wr_data = left_val + right_val;
      EFF_DEC: wr_data = left_val - right_val;
      default: wr_data = right_val;
    endcase
    if (item.op == OP_WRITE) begin
      wr_data = lit_val;
    end
  end

  assign is_effect_code = item.test_or_effect inside {EFF_SET, EFF_INC, EFF_DEC};

  assign ctl.wr_en     = ok && ((item.op == OP_EFFECT && is_effect_code) ||
                                item.op == OP_WRITE);
  assign ctl.chain_wr  = ok && (item.op == OP_CHECK);
  assign ctl.chain_val = chain_new;

  assign result.chain_result = ctl.chain_wr ? chain_new : running;
  assign result.read_value   = (ok && item.op == OP_READ) ? LIT_W'(left_val) : '0;
  assign result.ok           = ok;

endmodule

/* rtl/world_state_rule_evaluator.sv */
// Top level of the world-state rule evaluator: input and result registers, the value
// table with its valid bits and write forwarding, and the chain state.
// Depends on wsre_pkg, wsre_ram and wsre_exec.

// The block holds a table of signed world-state values that reset clears to zero, and
// evaluates one item per transfer: a condition check folded into a running AND/OR chain,
// an effect (set, increase, decrease with wraparound), a read or a write. Every key that
// an item uses is checked against keys_in_use; an item with a key out of range returns
// ok = 0 and changes nothing. Items are taken at one per clock cycle while the result
// is not stalled; the registered-read RAM captures the table entries at the transfer
// edge, while the item enters stage 1, and stage 1 then evaluates the item and loads
// the result register. A stalled result holds the item behind it in the input stage.
// The table is held twice, one copy for each of the two operands, so that both can be
// read in the same cycle. Each table entry carries a valid bit, so reset and a write of
// keys_in_use clear the table at once and an unwritten entry reads as zero; a register
// holding the most recent table write forwards its value to the item that follows
// directly behind it. keys_in_use may only be written while no item is in flight;
// values above NUM_KEYS are taken as NUM_KEYS, and zero makes every key out of range.
module world_state_rule_evaluator import wsre_pkg::*; #(
  parameter int NUM_KEYS    = NUM_KEYS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Keys are KEY_W bits wide, so entries beyond 2**KEY_W can never be reached.
  localparam int MEM_DEPTH = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [CFG_W-1:0] KEY_CAP =
    (NUM_KEYS >= (1 << CFG_W) - 1) ? {CFG_W{1'b1}} : CFG_W'(NUM_KEYS);
  localparam logic [CFG_W-1:0] KEYS_RESET =
    (KEY_CAP > CFG_W'(64)) ? CFG_W'(64) : KEY_CAP;

  // Configuration and chain state.
  logic [CFG_W-1:0] keys_in_use;
  logic             running_result;
  logic             previous_link;

  // Stage 1: the item whose table data is being read out.
  logic  s1_valid;
  item_t s1_item;
  logic  s1_fire;
  logic  accept;

  // Table valid bits and the most recent write, for forwarding.
  logic [MEM_DEPTH-1:0]          entry_valid;
  logic                          lw_valid;
  logic [AW-1:0]                 lw_addr;
  logic signed [VALUE_WIDTH-1:0] lw_data;

  logic [VALUE_WIDTH-1:0]        ram_left;
  logic [VALUE_WIDTH-1:0]        ram_right;
  logic [AW-1:0]                 left_idx;
  logic [AW-1:0]                 right_idx;
  logic signed [VALUE_WIDTH-1:0] left_val;
  logic signed [VALUE_WIDTH-1:0] right_entry;
  logic                          left_in_range;
  logic                          right_in_range;

  ctl_t                          ctl;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  result_t                       result_next;

  // The stage-1 item completes when the result register is free or being emptied, and
  // a new item may enter whenever stage 1 is empty or completing.
  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_in_use <= KEYS_RESET;
    end else if (cfg_wen) begin
      keys_in_use <= (cfg_wdata > KEY_CAP) ? KEY_CAP : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // Both table copies take every write; each serves one operand.
  wsre_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram_left (
    .clk   (clk),
    .we    (s1_fire && ctl.wr_en),
    .waddr (left_idx),
    .wdata (wr_data),
    .re    (accept),
    .raddr (item.left_key[AW-1:0]),
    .rdata (ram_left)
  );

  wsre_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram_right (
    .clk   (clk),
    .we    (s1_fire && ctl.wr_en),
    .waddr (left_idx),
    .wdata (wr_data),
    .re    (accept),
    .raddr (item.right_key[AW-1:0]),
    .rdata (ram_right)
  );

  assign left_idx       = s1_item.left_key[AW-1:0];
  assign right_idx      = s1_item.right_key[AW-1:0];
  assign left_in_range  = {1'b0, s1_item.left_key} < keys_in_use;
  assign right_in_range = {1'b0, s1_item.right_key} < keys_in_use;

  // The RAM returns the old contents when the item ahead wrote the same entry on the
  // cycle of the read, so the last write takes precedence; an entry never written since
  // the last clear reads as zero.
  always_comb begin
    if (lw_valid && lw_addr == left_idx) begin
      left_val = lw_data;
    end else if (entry_valid[left_idx]) begin
      left_val = ram_left;
    end else begin
      left_val = '0;
    end
    if (lw_valid && lw_addr == right_idx) begin
      right_entry = lw_data;
    end else if (entry_valid[right_idx]) begin
      right_entry = ram_right;
    end else begin
      right_entry = '0;
    end
  end

  wsre_exec #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_exec (
    .item           (s1_item),
    .left_in_range  (left_in_range),
    .right_in_range (right_in_range),
    .left_val       (left_val),
    .right_entry    (right_entry),
    .running        (running_result),
    .prev_link      (previous_link),
    .ctl            (ctl),
    .wr_data        (wr_data),
    .result         (result_next)
  );

  // Clearing the table on reset or on a keys_in_use write wins over any table write.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      entry_valid <= '0;
      lw_valid    <= 1'b0;
    end else if (s1_fire && ctl.wr_en) begin
      entry_valid[left_idx] <= 1'b1;
      lw_valid              <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ctl.wr_en) begin
      lw_addr <= left_idx;
      lw_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_result <= 1'b1;
      previous_link  <= 1'b0;
    end else if (s1_fire && ctl.chain_wr) begin
      running_result <= ctl.chain_val;
      previous_link  <= s1_item.link_to_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

  // A failed item never touches the table or the chain.
  a_fail_no_update: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !result_next.ok |-> !ctl.wr_en && !ctl.chain_wr)
    else $error("failed item requests a state update");

  // With the result register empty, the block always takes a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with an empty result register");

  // A keys_in_use write leaves the whole table cleared.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> entry_valid == '0 && !lw_valid)
    else $error("table not cleared after configuration write");

  // The forwarding register only ever holds an entry the table also marks written.
  a_forward_valid: assert property (@(posedge clk) disable iff (rst)
    lw_valid |-> entry_valid[lw_addr])
    else $error("forwarded entry is not marked valid");

endmodule
